// ----- hdl/gcdl_pkg.sv -----
// Shared constants and types for the GCD/LCM unit.
package gcdl_pkg;

  // Result field widths, fixed by the output item format
  localparam int unsigned DivisorBits  = 16;
  localparam int unsigned MultipleBits = 32;
  localparam int unsigned OutDataBits  = DivisorBits + MultipleBits;

  // Core status seen by the top level
  typedef struct packed {
    logic idle;      // ready for a new operand pair
    logic done;      // result held, waiting to be taken
    logic zero_err;  // an operand was zero
  } core_stat_t;

endpackage

// ----- hdl/gcdl_core.sv -----
// Iterative GCD/LCM core: binary GCD, restoring divide, shift-add multiply on one adder.
module gcdl_core import gcdl_pkg::*; #(
  parameter int unsigned OperandBits = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [OperandBits-1:0]     a_i,
  input  logic [OperandBits-1:0]     b_i,
  input  logic                       ack_i,
  output core_stat_t                 stat_o,
  output logic [OperandBits-1:0]     gcd_o,
  output logic [2*OperandBits-1:0]   lcm_o
);

  localparam int unsigned N  = OperandBits;
  localparam int unsigned AW = 2 * N;
  localparam int unsigned KW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGcd  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]    state_q, state_d;
  logic          err_q, err_d;
  logic [N-1:0]  opa_q, opa_d;
  logic [N-1:0]  opb_q, opb_d;
  logic [N-1:0]  x_q, x_d;
  logic [N-1:0]  y_q, y_d;
  logic [KW-1:0] k_q, k_d;
  logic [N-1:0]  g_q, g_d;
  logic [N-1:0]  rem_q, rem_d;
  logic [N-1:0]  quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [AW-1:0] mcand_q, mcand_d;
  logic [N-1:0]  mplier_q, mplier_d;

  // shared add/subtract unit; top bit is the borrow on subtract
  logic [AW-1:0] alu_x, alu_y;
  logic          alu_sub;
  logic [AW:0]   alu_res;
  logic          x_gt;
  logic          fits;

  assign alu_res = alu_sub ? ({1'b0, alu_x} - {1'b0, alu_y})
                           : ({1'b0, alu_x} + {1'b0, alu_y});
  assign x_gt    = x_q > y_q;
  assign fits    = ~alu_res[AW];

  // sequencer and datapath next state
  always_comb begin
    state_d  = state_q;
    err_d    = err_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    x_d      = x_q;
    y_d      = y_q;
    k_d      = k_q;
    g_d      = g_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    alu_x    = '0;
    alu_y    = '0;
    alu_sub  = 1'b1;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          opa_d = a_i;
          opb_d = b_i;
          x_d   = a_i;
          y_d   = b_i;
          k_d   = '0;
          if (a_i == '0 || b_i == '0) begin
            err_d   = 1'b1;
            g_d     = '0;
            acc_d   = '0;
            state_d = StDone;
          end else begin
            err_d   = 1'b0;
            state_d = StGcd;
          end
        end
      end
      StGcd: begin
        // larger minus smaller
        alu_x = AW'(x_gt ? x_q : y_q);
        alu_y = AW'(x_gt ? y_q : x_q);
        if (x_q == y_q) begin
          g_d     = x_q << k_q;
          rem_d   = '0;
          quo_d   = opa_q;
          cnt_d   = CW'(N);
          state_d = StDiv;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_gt) begin
          x_d = alu_res[N:1];
        end else begin
          y_d = alu_res[N:1];
        end
      end
      StDiv: begin
        // one quotient bit of opa / g per cycle
        alu_x = AW'({rem_q, quo_q[N-1]});
        alu_y = AW'(g_q);
        if (fits) begin
          rem_d = alu_res[N-1:0];
        end else begin
          rem_d = {rem_q[N-2:0], quo_q[N-1]};
        end
        quo_d = {quo_q[N-2:0], fits};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          acc_d    = '0;
          mcand_d  = AW'(quo_d);
          mplier_d = opb_q;
          cnt_d    = CW'(N);
          state_d  = StMul;
        end
      end
      StMul: begin
        // (opa / g) * opb, one multiplier bit per cycle
        alu_sub  = 1'b0;
        alu_x    = acc_q;
        alu_y    = mcand_q;
        if (mplier_q[0]) begin
          acc_d = alu_res[AW-1:0];
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (ack_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    x_q      <= x_d;
    y_q      <= y_d;
    k_q      <= k_d;
    g_q      <= g_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign stat_o.idle     = (state_q == StIdle);
  assign stat_o.done     = (state_q == StDone);
  assign stat_o.zero_err = err_q;
  assign gcd_o           = g_q;
  assign lcm_o           = acc_q;

endmodule

// ----- hdl/gcd_lcm_unit_top.sv -----
// Top level of the GCD/LCM unit: stream ports, iterative core, output register.
// The GCD loop, then an N-step divide and N-step multiply, share one adder.
// Throughput: one item at a time; tready is high only while the core is idle.
// Reset: rst_ni (async, active low) clears the sequencer and output valid.
module gcd_lcm_unit_top import gcdl_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // [N-1:0] first_value, [2N-1:N] second_value, zero padded to bytes
  input  logic [((2*OPERAND_BITS+7)/8)*8-1:0]       s_axis_tdata_i,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // [15:0] divisor_out, [47:16] multiple_out
  output logic [OutDataBits-1:0]                    m_axis_tdata_o,
  // [0] zero_operand_error
  output logic                                      m_axis_tuser_o
);

  core_stat_t                  stat;
  logic                        start;
  logic                        load;
  logic [OPERAND_BITS-1:0]     gcd_val;
  logic [2*OPERAND_BITS-1:0]   lcm_val;

  logic                        out_valid_q;
  logic [DivisorBits-1:0]      out_div_q;
  logic [MultipleBits-1:0]     out_mul_q;
  logic                        out_err_q;

  assign s_axis_tready_o = stat.idle;
  assign start           = s_axis_tvalid_i & stat.idle;
  assign load            = stat.done & (~out_valid_q | m_axis_tready_i);

  gcdl_core #(
    .OperandBits(OPERAND_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .a_i    (s_axis_tdata_i[OPERAND_BITS-1:0]),
    .b_i    (s_axis_tdata_i[2*OPERAND_BITS-1:OPERAND_BITS]),
    .ack_i  (load),
    .stat_o (stat),
    .gcd_o  (gcd_val),
    .lcm_o  (lcm_val)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, fitted to the result field widths
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_div_q <= DivisorBits'(gcd_val);
      out_mul_q <= MultipleBits'(lcm_val);
      out_err_q <= stat.zero_err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_mul_q, out_div_q};
  assign m_axis_tuser_o  = out_err_q;

endmodule
